[hw/rtl/bamc_pkg.sv]
// ----------------------------------------------------------------------------
// bamc_pkg
// Shared types, constants and helpers of the non-Archimedean arithmetic unit.
// ----------------------------------------------------------------------------
package bamc_pkg;

  localparam int NUM_COMPONENTS = 3;
  localparam int COMP_WIDTH     = 32;
  localparam int FRAC_BITS      = 16;
  localparam int EXP_WIDTH      = 8;
  // widened exponent: product sum plus normal-form lowering
  localparam int WEXP_WIDTH     = EXP_WIDTH + 2;
  // floored product, three terms summed
  localparam int PROD_WIDTH     = 2 * COMP_WIDTH - FRAC_BITS;
  localparam int ACC_WIDTH      = PROD_WIDTH + 2;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [EXP_WIDTH-1:0]  exp_t;
  typedef logic signed [WEXP_WIDTH-1:0] wexp_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic signed [ACC_WIDTH-1:0]  acc_t;

  localparam exp_t EXP_MAX = {1'b0, {(EXP_WIDTH-1){1'b1}}};
  localparam exp_t EXP_MIN = {1'b1, {(EXP_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    REQ_ADD = 3'd0,
    REQ_MUL = 3'd1,
    REQ_NEG = 3'd2,
    REQ_ABS = 3'd3,
    REQ_LT  = 3'd4,
    REQ_EQ  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    LSEL_SUM,
    LSEL_PROD,
    LSEL_NEG,
    LSEL_ZERO
  } lane_sel_e;

  typedef struct packed {
    logic signed [WEXP_WIDTH-1:0] exp;
    logic                         norm;
    logic                         cmp;
  } ctl_t;

  function automatic comp_t sat_acc(input acc_t v);
    acc_t hi_lim;
    acc_t lo_lim;
    hi_lim = {{(ACC_WIDTH-COMP_WIDTH+1){1'b0}}, {(COMP_WIDTH-1){1'b1}}};
    lo_lim = {{(ACC_WIDTH-COMP_WIDTH+1){1'b1}}, {(COMP_WIDTH-1){1'b0}}};
    if (v > hi_lim) return hi_lim[COMP_WIDTH-1:0];
    if (v < lo_lim) return lo_lim[COMP_WIDTH-1:0];
    return v[COMP_WIDTH-1:0];
  endfunction

endpackage

[hw/rtl/ban_add_mul_compare_unit.sv]
// ----------------------------------------------------------------------------
// ban_add_mul_compare_unit
// Add, multiply, negate, abs and compare for values made of an exponent of
// the infinite unit and three signed Q16.16 series components.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the request code and both operands with start high; a word is
//   taken at every rising edge where start is high and busy is low.
//   busy stays low, so one word may be issued on every clock.
//   The result sits on the ports with done_o high for one cycle, after the
//   lane registers and the merge output register; the receiver takes it then.
//   Latency is set by the pipeline: operand decode and the per-lane
//   multipliers, lane summing and saturation, then the merge stage that
//   brings sums and products to normal form and saturates the exponent.
//   Throughput is one word per cycle, three component lanes in parallel.
//   Compares return zero components and exponent with cmp_true_o; unused
//   request codes give an all-zero result.
//   Reset clears the valid pipeline so no done_o appears for words lost
//   in flight. There is no flow control on the result side.
// ----------------------------------------------------------------------------
module ban_add_mul_compare_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           req_type_i,
  input  bamc_pkg::exp_t       a_exp_i,
  input  bamc_pkg::comp_t      a_c0_i,
  input  bamc_pkg::comp_t      a_c1_i,
  input  bamc_pkg::comp_t      a_c2_i,
  input  bamc_pkg::exp_t       b_exp_i,
  input  bamc_pkg::comp_t      b_c0_i,
  input  bamc_pkg::comp_t      b_c1_i,
  input  bamc_pkg::comp_t      b_c2_i,
  output logic                 done_o,
  output bamc_pkg::exp_t       res_exp_o,
  output bamc_pkg::comp_t      res_c0_o,
  output bamc_pkg::comp_t      res_c1_o,
  output bamc_pkg::comp_t      res_c2_o,
  output logic                 cmp_true_o,
  output logic                 exp_overflow_o
);
  import bamc_pkg::*;

  comp_t a_c [NUM_COMPONENTS];
  comp_t b_c [NUM_COMPONENTS];
  comp_t hi_c [NUM_COMPONENTS];
  comp_t lo_c [NUM_COMPONENTS];
  comp_t lo_al [NUM_COMPONENTS];
  comp_t mx [NUM_COMPONENTS][NUM_COMPONENTS];
  comp_t my [NUM_COMPONENTS][NUM_COMPONENTS];
  logic [NUM_COMPONENTS-1:0] men [NUM_COMPONENTS];
  comp_t lane_res [NUM_COMPONENTS];
  comp_t res_c [NUM_COMPONENTS];

  lane_sel_e sel;
  ctl_t      ctl_d, ctl1_q, ctl2_q;
  logic      v1_q, v2_q, done_q;
  logic      accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign a_c[0] = a_c0_i;
  assign a_c[1] = a_c1_i;
  assign a_c[2] = a_c2_i;
  assign b_c[0] = b_c0_i;
  assign b_c[1] = b_c1_i;
  assign b_c[2] = b_c2_i;

  // operand decode: alignment, request to lane select, compares
  always_comb begin
    logic a_zero, b_zero, lo_en, b_hi, decided, lt, eq;
    logic signed [EXP_WIDTH:0] d;
    logic [1:0] sh;
    exp_t hi_e;

    a_zero  = (a_exp_i == '0) && (a_c[0] == '0);
    b_zero  = (b_exp_i == '0) && (b_c[0] == '0);
    d       = (EXP_WIDTH+1)'(a_exp_i) - (EXP_WIDTH+1)'(b_exp_i);
    lo_en   = 1'b0;
    b_hi    = 1'b0;
    sh      = '0;
    decided = 1'b0;
    if (a_zero) begin
      b_hi = 1'b1;
    end else if (b_zero) begin
      b_hi = 1'b0;
    end else if (d >= (EXP_WIDTH+1)'(NUM_COMPONENTS)) begin
      b_hi = 1'b0;
    end else if (d <= -(EXP_WIDTH+1)'(NUM_COMPONENTS)) begin
      b_hi = 1'b1;
    end else begin
      lo_en = 1'b1;
      b_hi  = d < 0;
      sh    = b_hi ? 2'(-d) : 2'(d);
    end
    hi_e = b_hi ? b_exp_i : a_exp_i;

    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      hi_c[i]  = b_hi ? b_c[i] : a_c[i];
      lo_c[i]  = b_hi ? a_c[i] : b_c[i];
      lo_al[i] = '0;
      for (int j = 0; j < NUM_COMPONENTS; j++) begin
        if (lo_en && i == j + int'(sh)) lo_al[i] = lo_c[j];
      end
    end

    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      for (int j = 0; j < NUM_COMPONENTS; j++) begin
        mx[i][j]  = '0;
        my[i][j]  = '0;
        men[i][j] = 1'b0;
      end
      for (int j = 0; j <= i; j++) begin
        mx[i][j]  = a_c[i-j];
        my[i][j]  = b_c[j];
        men[i][j] = !(a_zero || b_zero);
      end
    end

    // less-than and equality
    if (a_exp_i < b_exp_i) begin
      lt = (b_c[0] > 0) || (b_c[0] == '0 && a_c[0] < 0);
    end else if (a_exp_i > b_exp_i) begin
      lt = (a_c[0] < 0) || (a_c[0] == '0 && b_c[0] > 0);
    end else begin
      lt      = 1'b0;
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        if (!decided && a_c[i] != b_c[i]) begin
          decided = 1'b1;
          lt      = a_c[i] < b_c[i];
        end
      end
    end
    eq = (a_exp_i == b_exp_i);
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      eq = eq && (a_c[i] == b_c[i]);
    end

    ctl_d = '0;
    sel   = LSEL_ZERO;
    unique case (req_type_i)
      REQ_ADD: begin
        sel          = LSEL_SUM;
        ctl_d.exp    = WEXP_WIDTH'(hi_e);
        ctl_d.norm   = lo_en;
      end
      REQ_MUL: begin
        sel          = LSEL_PROD;
        ctl_d.exp    = WEXP_WIDTH'(a_exp_i) + WEXP_WIDTH'(b_exp_i);
        ctl_d.norm   = 1'b1;
      end
      REQ_NEG: begin
        sel          = LSEL_NEG;
        ctl_d.exp    = WEXP_WIDTH'(a_exp_i);
      end
      REQ_ABS: begin
        sel          = (a_c[0] < 0) ? LSEL_NEG : LSEL_SUM;
        ctl_d.exp    = WEXP_WIDTH'(a_exp_i);
      end
      REQ_LT:  ctl_d.cmp = lt;
      REQ_EQ:  ctl_d.cmp = eq;
      default: ctl_d = '0;
    endcase

    // negate and abs act on a alone
    if (req_type_i == REQ_NEG || req_type_i == REQ_ABS) begin
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        hi_c[i]  = a_c[i];
        lo_al[i] = '0;
      end
    end
  end

  for (genvar g = 0; g < NUM_COMPONENTS; g++) begin : g_lane
    bamc_lane u_lane (
      .clk_i (clk_i),
      .mx_i  (mx[g]),
      .my_i  (my[g]),
      .men_i (men[g]),
      .hi_i  (hi_c[g]),
      .lo_i  (lo_al[g]),
      .sel_i (sel),
      .res_o (lane_res[g])
    );
  end

  always_ff @(posedge clk_i) begin
    ctl1_q <= ctl_d;
    ctl2_q <= ctl1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= accept;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  bamc_merge u_merge (
    .clk_i (clk_i),
    .ctl_i (ctl2_q),
    .c_i   (lane_res),
    .exp_o (res_exp_o),
    .c_o   (res_c),
    .cmp_o (cmp_true_o),
    .ovf_o (exp_overflow_o)
  );

  assign res_c0_o = res_c[0];
  assign res_c1_o = res_c[1];
  assign res_c2_o = res_c[2];
  assign done_o   = done_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("accepted word did not complete in three cycles");

  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && cmp_true_o) |-> (res_exp_o == '0 && res_c0_o == '0 && !exp_overflow_o))
    else $error("compare result carries a value");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && exp_overflow_o) |-> (res_exp_o == EXP_MAX || res_exp_o == EXP_MIN))
    else $error("overflow flagged without saturated exponent");

  a_norm_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(ctl2_q.norm) && res_c0_o == '0) |->
      (res_exp_o == '0 && res_c1_o == '0))
    else $error("normalised result has a leading zero");
`endif

endmodule

[hw/rtl/bamc_lane.sv]
// ----------------------------------------------------------------------------
// bamc_lane
// One component lane: floored partial products, aligned sum and negation,
// two register stages.
// ----------------------------------------------------------------------------
module bamc_lane (
  input  logic                                         clk_i,
  input  bamc_pkg::comp_t                              mx_i [bamc_pkg::NUM_COMPONENTS],
  input  bamc_pkg::comp_t                              my_i [bamc_pkg::NUM_COMPONENTS],
  input  logic [bamc_pkg::NUM_COMPONENTS-1:0]          men_i,
  input  bamc_pkg::comp_t                              hi_i,
  input  bamc_pkg::comp_t                              lo_i,
  input  bamc_pkg::lane_sel_e                          sel_i,
  output bamc_pkg::comp_t                              res_o
);
  import bamc_pkg::*;

  prod_t     p_q [NUM_COMPONENTS];
  comp_t     hi_q, lo_q;
  lane_sel_e sel_q;
  comp_t     res_d, res_q;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NUM_COMPONENTS; j++) begin
      logic signed [2*COMP_WIDTH-1:0] full;
      full = (2*COMP_WIDTH)'(mx_i[j]) * (2*COMP_WIDTH)'(my_i[j]);
      // arithmetic shift floors the product
      p_q[j] <= men_i[j] ? prod_t'(full >>> FRAC_BITS) : '0;
    end
    hi_q  <= hi_i;
    lo_q  <= lo_i;
    sel_q <= sel_i;
  end

  always_comb begin
    acc_t acc;
    acc = '0;
    for (int j = 0; j < NUM_COMPONENTS; j++) begin
      acc = acc + ACC_WIDTH'(p_q[j]);
    end
    unique case (sel_q)
      LSEL_SUM:  res_d = sat_acc(ACC_WIDTH'(hi_q) + ACC_WIDTH'(lo_q));
      LSEL_PROD: res_d = sat_acc(acc);
      LSEL_NEG:  res_d = sat_acc(-ACC_WIDTH'(hi_q));
      default:   res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

[hw/rtl/bamc_merge.sv]
// ----------------------------------------------------------------------------
// bamc_merge
// Combines lane results: normal form, exponent saturation, output register.
// ----------------------------------------------------------------------------
module bamc_merge (
  input  logic                 clk_i,
  input  bamc_pkg::ctl_t       ctl_i,
  input  bamc_pkg::comp_t      c_i [bamc_pkg::NUM_COMPONENTS],
  output bamc_pkg::exp_t       exp_o,
  output bamc_pkg::comp_t      c_o [bamc_pkg::NUM_COMPONENTS],
  output logic                 cmp_o,
  output logic                 ovf_o
);
  import bamc_pkg::*;

  comp_t c_d [NUM_COMPONENTS];
  comp_t c_q [NUM_COMPONENTS];
  exp_t  exp_d, exp_q;
  logic  ovf_d, ovf_q, cmp_q;

  always_comb begin
    wexp_t e;
    logic  found;
    logic  [1:0] idx;
    e     = ctl_i.exp;
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      c_d[i] = c_i[i];
    end
    if (ctl_i.norm && c_i[0] == '0) begin
      for (int i = 1; i < NUM_COMPONENTS; i++) begin
        if (!found && c_i[i] != '0) begin
          found = 1'b1;
          idx   = 2'(i);
        end
      end
      if (!found) begin
        e = '0;
      end else begin
        for (int i = 0; i < NUM_COMPONENTS; i++) begin
          c_d[i] = '0;
          for (int j = i + 1; j < NUM_COMPONENTS; j++) begin
            if (idx == 2'(j - i)) c_d[i] = c_i[j];
          end
        end
        e = e - WEXP_WIDTH'(idx);
      end
    end
    ovf_d = 1'b0;
    exp_d = e[EXP_WIDTH-1:0];
    if (e > WEXP_WIDTH'(EXP_MAX)) begin
      exp_d = EXP_MAX;
      ovf_d = 1'b1;
    end else if (e < WEXP_WIDTH'(EXP_MIN)) begin
      exp_d = EXP_MIN;
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q   <= c_d;
    exp_q <= exp_d;
    ovf_q <= ovf_d;
    cmp_q <= ctl_i.cmp;
  end

  assign c_o   = c_q;
  assign exp_o = exp_q;
  assign cmp_o = cmp_q;
  assign ovf_o = ovf_q;

endmodule

[tb/ban_add_mul_compare_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ban_add_mul_compare_unit_test
// Drives directed and random request words into the arithmetic unit, in
// bursts with gaps, and checks every result word against a table entry or a
// model of the sum, product, negation, abs and compare rules.
// ----------------------------------------------------------------------------
module ban_add_mul_compare_unit_test;
  import bamc_pkg::*;

  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;
  localparam comp_t CMAX = 32'sh7fff_ffff;
  localparam comp_t CMIN = 32'sh8000_0000;
  localparam comp_t ONE  = 32'sh0001_0000;
  localparam int    N_RANDOM    = 1330;
  localparam int    STALL_LIMIT = 2000;

  typedef struct packed {
    logic [2:0] req;
    exp_t       ae;
    comp_t      a0, a1, a2;
    exp_t       be;
    comp_t      b0, b1, b2;
  } word_t;

  typedef struct packed {
    exp_t  e;
    comp_t c0, c1, c2;
    logic  cmp;
    logic  ovf;
  } res_t;

  typedef struct {
    word_t w;
    bit    typed;
    res_t  want;
  } row_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy, done;
  word_t word_q = '0;
  bit    typed_q = 1'b0;
  res_t  want_q = '0;
  res_t  got;
  res_t  pending_q[$];
  int    errors = 0;
  int    idle_cycles = 0;

  ban_add_mul_compare_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (word_q.req),
    .a_exp_i        (word_q.ae),
    .a_c0_i         (word_q.a0),
    .a_c1_i         (word_q.a1),
    .a_c2_i         (word_q.a2),
    .b_exp_i        (word_q.be),
    .b_c0_i         (word_q.b0),
    .b_c1_i         (word_q.b1),
    .b_c2_i         (word_q.b2),
    .done_o         (done),
    .res_exp_o      (got.e),
    .res_c0_o       (got.c0),
    .res_c1_o       (got.c1),
    .res_c2_o       (got.c2),
    .cmp_true_o     (got.cmp),
    .exp_overflow_o (got.ovf)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint clamp_comp(longint v);
    if (v > longint'(CMAX)) return longint'(CMAX);
    if (v < longint'(CMIN)) return longint'(CMIN);
    return v;
  endfunction

  // leading zeros shift the series left; all-zero value gets exponent zero
  function automatic void lead_align(ref longint e, ref longint c[3]);
    int lead;
    lead = 0;
    if (c[0] != 0) return;
    for (int i = 2; i >= 1; i--) if (c[i] != 0) lead = i;
    if (lead == 0) begin
      e = 0;
      c = '{0, 0, 0};
      return;
    end
    for (int i = 0; i < 3; i++) c[i] = (i + lead < 3) ? c[i + lead] : 0;
    e -= lead;
  endfunction

  function automatic res_t arith_result(word_t w);
    longint ae, be, re, d, acc;
    longint ac[3], bc[3], rc[3], hc[3], lc[3];
    bit     a_zero, b_zero, cmp;
    res_t   r;
    ae = longint'(w.ae);
    be = longint'(w.be);
    ac = '{longint'(w.a0), longint'(w.a1), longint'(w.a2)};
    bc = '{longint'(w.b0), longint'(w.b1), longint'(w.b2)};
    a_zero = (ae == 0 && ac[0] == 0);
    b_zero = (be == 0 && bc[0] == 0);
    re = 0;
    rc = '{0, 0, 0};
    cmp = 1'b0;
    case (w.req)
      REQ_ADD: begin
        d = ae - be;
        if (a_zero) begin
          re = be; rc = bc;
        end else if (b_zero || d >= 3) begin
          re = ae; rc = ac;
        end else if (d <= -3) begin
          re = be; rc = bc;
        end else begin
          if (d < 0) begin
            re = be; hc = bc; lc = ac; d = -d;
          end else begin
            re = ae; hc = ac; lc = bc;
          end
          rc = hc;
          for (int i = int'(d); i < 3; i++) rc[i] = clamp_comp(hc[i] + lc[i - int'(d)]);
          lead_align(re, rc);
        end
      end
      REQ_MUL: begin
        if (!a_zero && !b_zero) begin
          re = ae + be;
          for (int i = 0; i < 3; i++) begin
            acc = 0;
            // each term floored before summing
            for (int j = 0; j <= i; j++) acc += (ac[i - j] * bc[j]) >>> FRAC_BITS;
            rc[i] = clamp_comp(acc);
          end
          lead_align(re, rc);
        end
      end
      REQ_NEG, REQ_ABS: begin
        re = ae;
        rc = ac;
        if (w.req == REQ_NEG || ac[0] < 0)
          for (int i = 0; i < 3; i++) rc[i] = clamp_comp(-ac[i]);
      end
      REQ_LT: begin
        if (ae < be) cmp = bc[0] > 0 || (bc[0] == 0 && ac[0] < 0);
        else if (ae > be) cmp = ac[0] < 0 || (ac[0] == 0 && bc[0] > 0);
        else begin
          for (int i = 2; i >= 0; i--)
            if (ac[i] != bc[i]) cmp = ac[i] < bc[i];
        end
      end
      REQ_EQ: cmp = (ae == be && ac == bc);
      default: ;
    endcase
    r.ovf = 1'b0;
    if (re > longint'(EXP_MAX)) begin
      re = longint'(EXP_MAX); r.ovf = 1'b1;
    end
    if (re < longint'(EXP_MIN)) begin
      re = longint'(EXP_MIN); r.ovf = 1'b1;
    end
    r.e   = exp_t'(re);
    r.c0  = comp_t'(rc[0]);
    r.c1  = comp_t'(rc[1]);
    r.c2  = comp_t'(rc[2]);
    r.cmp = cmp;
    return r;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return comp_t'($urandom_range(0, 32'h3_ffff)) * ($urandom_range(0, 1) ? 1 : -1);
      2: return $urandom_range(0, 1) ? CMAX : CMIN;
      3: return comp_t'((int'($urandom_range(0, 20)) - 10) <<< FRAC_BITS);
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic exp_t rand_exp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? EXP_MAX : EXP_MIN;
      1: return exp_t'($urandom);
      default: return exp_t'(int'($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  function automatic word_t rand_word();
    word_t w;
    w.req = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    w.ae = rand_exp();
    w.a0 = rand_comp(); w.a1 = rand_comp(); w.a2 = rand_comp();
    w.be = rand_exp();
    w.b0 = rand_comp(); w.b1 = rand_comp(); w.b2 = rand_comp();
    // equal operands now and then, so equality and ties are hit
    if ($urandom_range(0, 5) == 0) {w.be, w.b0, w.b1, w.b2} = {w.ae, w.a0, w.a1, w.a2};
    return w;
  endfunction

  task automatic issue(word_t w, bit typed, res_t want);
    word_q  <= w;
    typed_q <= typed;
    want_q  <= want;
    start   <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic report(string field, longint want, longint act);
    if (want != act) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, act);
    end
  endtask

  // word taken: work out its result
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy)
      pending_q.push_back(typed_q ? want_q : arith_result(word_q));
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, actual %h", $time, got);
      end else begin
        want = pending_q.pop_front();
        report("res_exp", want.e, got.e);
        report("res_c0", want.c0, got.c0);
        report("res_c1", want.c1, got.c1);
        report("res_c2", want.c2, got.c2);
        report("cmp_true", want.cmp, got.cmp);
        report("exp_overflow", want.ovf, got.ovf);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    word_t w;
    int burst;
    rows = '{
      '{'{REQ_ADD, 8'sd0, 32'sd0, 32'sd0, 32'sd0, 8'sd0, 32'sd0, 32'sd0, 32'sd0}, 1, '0},
      '{'{REQ_EQ, 8'sd0, 32'sd0, 32'sd0, 32'sd0, 8'sd0, 32'sd0, 32'sd0, 32'sd0}, 1,
        '{8'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0}},
      '{'{REQ_SPARE6, EXP_MAX, CMAX, CMIN, ONE, EXP_MIN, CMIN, CMAX, ONE}, 1, '0},
      '{'{REQ_SPARE7, 8'sd3, ONE, ONE, ONE, 8'sd3, ONE, ONE, ONE}, 1, '0},
      // product exponent leaves its range both ways
      '{'{REQ_MUL, EXP_MAX, ONE, 32'sd0, 32'sd0, EXP_MAX, ONE, 32'sd0, 32'sd0}, 1,
        '{EXP_MAX, ONE, 32'sd0, 32'sd0, 1'b0, 1'b1}},
      '{'{REQ_MUL, EXP_MIN, ONE, 32'sd0, 32'sd0, EXP_MIN, ONE, 32'sd0, 32'sd0}, 1,
        '{EXP_MIN, ONE, 32'sd0, 32'sd0, 1'b0, 1'b1}},
      '{'{REQ_NEG, 8'sd2, CMIN, 32'sd1, 32'sd0, 8'sd0, 32'sd0, 32'sd0, 32'sd0}, 1,
        '{8'sd2, CMAX, -32'sd1, 32'sd0, 1'b0, 1'b0}},
      '{'{REQ_ABS, -8'sd5, -ONE, CMIN, 32'sd7, 8'sd0, 32'sd0, 32'sd0, 32'sd0}, 0, '0},
      '{'{REQ_ABS, 8'sd5, ONE, CMIN, 32'sd7, 8'sd0, 32'sd0, 32'sd0, 32'sd0}, 0, '0},
      // distant exponents keep the operand with the larger exponent
      '{'{REQ_ADD, 8'sd4, ONE, 32'sd1, 32'sd2, 8'sd1, ONE, ONE, ONE}, 0, '0},
      '{'{REQ_ADD, -8'sd3, ONE, 32'sd1, 32'sd2, 8'sd1, -ONE, ONE, ONE}, 0, '0},
      // cancellation, in full and of the leading component
      '{'{REQ_ADD, 8'sd1, 32'sd5, 32'sd1, 32'sd2, 8'sd1, -32'sd5, -32'sd1, -32'sd2}, 1, '0},
      '{'{REQ_ADD, 8'sd0, 32'sd5, 32'sd3, 32'sd0, 8'sd0, -32'sd5, 32'sd0, 32'sd9}, 0, '0},
      // normal form drops the exponent below its range
      '{'{REQ_ADD, EXP_MIN, 32'sd5, 32'sd3, 32'sd0, EXP_MIN, -32'sd5, 32'sd0, 32'sd0}, 1,
        '{EXP_MIN, 32'sd3, 32'sd0, 32'sd0, 1'b0, 1'b1}},
      '{'{REQ_ADD, 8'sd0, CMAX, CMIN, CMAX, 8'sd0, CMAX, CMIN, ONE}, 0, '0},
      '{'{REQ_ADD, 8'sd0, 32'sd0, 32'sd0, 32'sd7, 8'sd5, 32'sd0, 32'sd0, 32'sd7}, 1,
        '{8'sd5, 32'sd0, 32'sd0, 32'sd7, 1'b0, 1'b0}},
      '{'{REQ_MUL, 8'sd0, 32'sd0, ONE, ONE, 8'sd2, ONE, ONE, ONE}, 1, '0},
      '{'{REQ_MUL, 8'sd1, CMAX, CMIN, CMAX, -8'sd1, CMIN, CMIN, CMAX}, 0, '0},
      '{'{REQ_MUL, 8'sd0, -32'sd1, 32'sd3, -ONE, 8'sd0, 32'sd1, -32'sd3, ONE}, 0, '0},
      '{'{REQ_LT, 8'sd1, -ONE, 32'sd0, 32'sd0, 8'sd0, ONE, 32'sd0, 32'sd0}, 0, '0},
      '{'{REQ_LT, -8'sd1, 32'sd0, 32'sd0, 32'sd0, 8'sd0, 32'sd0, ONE, 32'sd0}, 0, '0},
      '{'{REQ_LT, 8'sd0, ONE, ONE, 32'sd1, 8'sd0, ONE, ONE, 32'sd2}, 0, '0},
      '{'{REQ_EQ, 8'sd0, ONE, ONE, 32'sd1, 8'sd0, ONE, ONE, 32'sd2}, 0, '0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) issue(rows[i].w, rows[i].typed, rows[i].want);
    pause(1);

    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
        w = rand_word();
        issue(w, 1'b0, '0);
      end
      if (n > N_RANDOM / 2 && n - burst <= N_RANDOM / 2) begin
        start <= 1'b0;
        wait (pending_q.size() == 0);
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) != 0) begin
        pause($urandom_range(1, 8));
      end
    end
    start <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
